@@ hdl/reinhard_tone_map_macros.svh @@
// Assertion macros for the Reinhard tone mapper.
// Used by the top level only; expects a clock named clk and a reset named rst_n.
`ifndef REINHARD_TONE_MAP_MACROS_SVH
`define REINHARD_TONE_MAP_MACROS_SVH

// Implication checked at every edge outside reset.
`define RTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, checked through reset as well.
`define RTM_ASSERT_NEXT_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rtm_pkg.sv @@
// Shared constants and pipeline stage types for the Reinhard tone mapper.
// No dependencies.
package rtm_pkg;

  localparam int IN_W          = 32;
  localparam int LEVEL_W       = 8;
  localparam int NUM_W         = 40;  // 255 * intensity stays below 2^40
  localparam int DEN_W         = 33;  // 2^FRAC_BITS + intensity stays below 2^33
  localparam int LANES         = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [LEVEL_W-1:0] LEVEL_SCALE = 8'd255;

  typedef struct packed {
    logic [NUM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [LEVEL_W-1:0] quo;
  } rtm_lane_t;

  typedef struct packed {
    rtm_lane_t [LANES-1:0] lane;
    logic                  eof;
  } rtm_stage_t;

endpackage

@@ hdl/rtm_prep.sv @@
// Entry stage: forms numerator 255*x and denominator 2^FRAC_BITS + x per channel.
// Depends on rtm_pkg.
module rtm_prep #(
  parameter int FRAC_BITS = rtm_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         up_valid,
  output logic                                         up_ready,
  input  logic [rtm_pkg::LANES-1:0][rtm_pkg::IN_W-1:0] up_val,
  input  logic                                         up_eof,
  output logic                                         dn_valid,
  input  logic                                         dn_ready,
  output rtm_pkg::rtm_stage_t                          dn_data
);
  import rtm_pkg::*;

  localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;

  logic       valid_r;
  rtm_stage_t data_r;
  rtm_stage_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // 255 * v is (v << 8) - v.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      data_nxt.lane[i].rem = {up_val[i], 8'b0} - {8'b0, up_val[i]};
      data_nxt.lane[i].den = ONE + {1'b0, up_val[i]};
      data_nxt.lane[i].quo = '0;
    end
    data_nxt.eof = up_eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ hdl/rtm_div_stage.sv @@
// One restoring-division stage: decides quotient bit BIT for all three channels.
// Depends on rtm_pkg.
module rtm_div_stage #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  rtm_pkg::rtm_stage_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rtm_pkg::rtm_stage_t dn_data
);
  import rtm_pkg::*;

  logic       valid_r;
  rtm_stage_t data_r;
  rtm_stage_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    logic [NUM_W-1:0] dsh;
    logic [NUM_W:0]   diff;
    data_nxt = up_data;
    for (int i = 0; i < LANES; i++) begin
      dsh  = {{(NUM_W-DEN_W){1'b0}}, up_data.lane[i].den} << BIT;
      diff = {1'b0, up_data.lane[i].rem} - {1'b0, dsh};
      if (!diff[NUM_W]) begin
        data_nxt.lane[i].rem      = diff[NUM_W-1:0];
        data_nxt.lane[i].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ hdl/reinhard_tone_map.sv @@
// Reinhard global tone mapper, top level.
// Depends on rtm_pkg, rtm_prep, rtm_div_stage and reinhard_tone_map_macros.svh.
//
// Usage:
//   Each input request carries one pixel: three 32-bit unsigned radiance values
//   with FRAC_BITS fraction bits and an end-of-frame flag. Each result request
//   carries the three 8-bit display levels floor(255 * x / (1 + x)) and a copy
//   of the flag in frame_done. Both channels use a valid/ready handshake.
//   One stage forms numerator and denominator, then eight stages each resolve
//   one quotient bit with a 41-bit compare and subtract. Throughput is one
//   pixel per cycle while the output is not stalled; every stage holds a valid
//   bit and advances whenever its successor is empty or moving.
//   When the receiver stalls, the pipeline fills up bubble by bubble and
//   in_ready drops only once every stage holds a pixel; nothing is lost or
//   repeated. A synchronous reset (rst_n low) clears all valid bits; the data
//   registers are not reset.
module reinhard_tone_map #(
  parameter int FRAC_BITS = rtm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rtm_pkg::IN_W-1:0]     in_red_intensity,
  input  logic [rtm_pkg::IN_W-1:0]     in_green_intensity,
  input  logic [rtm_pkg::IN_W-1:0]     in_blue_intensity,
  input  logic                         in_end_of_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rtm_pkg::LEVEL_W-1:0]  out_red_level,
  output logic [rtm_pkg::LEVEL_W-1:0]  out_green_level,
  output logic [rtm_pkg::LEVEL_W-1:0]  out_blue_level,
  output logic                         out_frame_done
);
  import rtm_pkg::*;
  `include "reinhard_tone_map_macros.svh"

  // Stage 0 is the entry stage; stage k+1 holds quotient bits down to 7-k.
  localparam int NSTG = LEVEL_W + 1;

  logic       stg_valid [NSTG];
  logic       stg_ready [NSTG];
  rtm_stage_t stg_data  [NSTG];

  logic [LANES-1:0][IN_W-1:0] in_val;

  // Lane order: red, green, blue.
  assign in_val[0] = in_red_intensity;
  assign in_val[1] = in_green_intensity;
  assign in_val[2] = in_blue_intensity;

  rtm_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_val   (in_val),
    .up_eof   (in_end_of_frame),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_data  (stg_data[0])
  );

  // Quotient bits are resolved from the most significant down.
  for (genvar k = 0; k < LEVEL_W; k++) begin : g_div
    rtm_div_stage #(
      .BIT(LEVEL_W - 1 - k)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_data  (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_data  (stg_data[k+1])
    );
  end

  assign stg_ready[NSTG-1] = out_ready;

  assign out_valid       = stg_valid[NSTG-1];
  assign out_red_level   = stg_data[NSTG-1].lane[0].quo;
  assign out_green_level = stg_data[NSTG-1].lane[1].quo;
  assign out_blue_level  = stg_data[NSTG-1].lane[2].quo;
  assign out_frame_done  = stg_data[NSTG-1].eof;

  // The quotient is always below 255, so a delivered level never reaches full scale.
  `RTM_ASSERT_IMP(a_level_below_max, out_valid && out_ready,
                  (out_red_level != 8'hFF) && (out_green_level != 8'hFF) &&
                  (out_blue_level != 8'hFF),
                  "tone-mapped level reached 255")
  // With the output moving or empty, the whole pipeline moves and must take a request.
  `RTM_ASSERT_IMP(a_ready_when_draining, !out_valid || out_ready, in_ready,
                  "input stalled while output drains")
  // Reset empties every stage.
  `RTM_ASSERT_NEXT_RAW(a_empty_after_reset, !rst_n, !out_valid,
                       "result valid right after reset")

endmodule
